### hdl/cis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cis_pkg: shared types and constants for the cone isolation sum core
// Queue word layout, configuration bundle, register indexes, angle constants.
// ----------------------------------------------------------------------------
package cis_pkg;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MIN_PT    = 3'd0;
  localparam logic [2:0] REG_CONE_DR2  = 3'd1;
  localparam logic [2:0] REG_SELF_VETO = 3'd2;
  localparam logic [2:0] REG_MAX_TRANS = 3'd3;
  localparam logic [2:0] REG_MAX_LONG  = 3'd4;

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  // angles in 1/1024 rad
  localparam logic [11:0]        ANG_PI     = 12'd3217;
  localparam logic signed [13:0] ANG_TWO_PI = 14'sd6434;

  localparam logic [23:0] SUM_MAX   = 24'hFFFFFF;
  localparam int          DIV_STEPS = 32;

  typedef struct packed {
    logic [15:0] min_pt;
    logic [26:0] cone_dr2;
    logic [9:0]  self_veto_dr2;
    logic [14:0] max_trans;
    logic [14:0] max_long;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic        start;    // probe word: load probe pt, clear sums
    logic        last;     // end of event, emit result
    logic        add_all;  // pt goes into the all-particle sum
    logic        add_chg;  // pt goes into the charged sum
    logic [15:0] pt;
  } entry_t;

endpackage : cis_pkg
`default_nettype wire

### hdl/cone_isolation_sum_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cone_isolation_sum_core: per-event pt cone isolation of one probe particle
// Start word loads the probe, candidate words accumulate cone sums, the last
// word of an event yields both sums and both relative isolations.
// ----------------------------------------------------------------------------
// Rate and flow: the front takes one input word per clock while in_stall
// is low and classifies it in a three stage pipeline (delta eta/phi, phi
// fold plus eta square, phi square), then pushes it into a QUEUE_DEPTH
// word queue. The back pops one word per clock while idle and the queue is
// not empty and updates the saturating sums, so candidates stream at one
// per cycle while the back is idle. A word with last set takes the back
// through its own pop, a setup state, 32 steps of the restoring dividers
// for probe_pt*65536/(sum+probe_pt) and a done state that loads the
// output register; meanwhile the queue fills and then in_stall rises, as
// the pipeline plus queue hold only QUEUE_DEPTH+3 words. A last word passes
// the front stages and the queue, then the setup, divider and done states,
// before its result is loaded. Results wait in an output register, so the
// back keeps popping words while out_stall is high until the next result is
// ready; then the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
module cone_isolation_sum_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input words
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic [15:0]        in_pt,
  input  wire logic signed [13:0] in_eta,
  input  wire logic signed [12:0] in_phi,
  input  wire logic signed [1:0]  in_charge,
  input  wire logic signed [15:0] in_dxy,
  input  wire logic signed [15:0] in_dz,
  input  wire logic               in_last,
  // result words
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [23:0]             out_sum_all,
  output logic [23:0]             out_sum_charged,
  output logic [16:0]             out_iso_all,
  output logic [16:0]             out_iso_charged
);
  import cis_pkg::*;

  // configuration registers, reset to the nominal analysis cuts
  logic [15:0] min_pt_r;
  logic [26:0] cone_dr2_r;      // 0.3 cone squared
  logic [9:0]  self_veto_r;     // about 0.001 squared radius
  logic [14:0] max_trans_r;     // 0.2 cm
  logic [14:0] max_long_r;      // 0.5 cm
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  cfg_t        cfg;

  // front/back hand-off
  entry_t      push_entry, pop_entry;
  logic        q_push, q_pop, q_full, q_empty;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pt_r    <= 16'd8;
      cone_dr2_r  <= 27'd94372;
      self_veto_r <= 10'd2;
      max_trans_r <= 15'd205;
      max_long_r  <= 15'd512;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_PT:    min_pt_r    <= pwdata[15:0];
        REG_CONE_DR2:  cone_dr2_r  <= pwdata[26:0];
        REG_SELF_VETO: self_veto_r <= pwdata[9:0];
        REG_MAX_TRANS: max_trans_r <= pwdata[14:0];
        REG_MAX_LONG:  max_long_r  <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // read back; unmapped addresses read zero
  always_comb begin
    case (cfg_idx)
      REG_MIN_PT:    prdata = {16'd0, min_pt_r};
      REG_CONE_DR2:  prdata = {5'd0, cone_dr2_r};
      REG_SELF_VETO: prdata = {22'd0, self_veto_r};
      REG_MAX_TRANS: prdata = {17'd0, max_trans_r};
      REG_MAX_LONG:  prdata = {17'd0, max_long_r};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.min_pt        = min_pt_r;
    cfg.cone_dr2      = cone_dr2_r;
    cfg.self_veto_dr2 = self_veto_r;
    cfg.max_trans     = max_trans_r;
    cfg.max_long      = max_long_r;
  end

  // front: accept, hold probe direction, classify against the cone
  cis_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_pt        (in_pt),
    .in_eta       (in_eta),
    .in_phi       (in_phi),
    .in_charge    (in_charge),
    .in_dxy       (in_dxy),
    .in_dz        (in_dz),
    .in_last      (in_last),
    .q_push       (q_push),
    .q_entry      (push_entry),
    .q_full       (q_full)
  );

  // decoupling queue
  cis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // back: sums, dividers, output register
  cis_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_entry         (pop_entry),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_all     (out_sum_all),
    .out_sum_charged (out_sum_charged),
    .out_iso_all     (out_iso_all),
    .out_iso_charged (out_iso_charged)
  );

endmodule : cone_isolation_sum_core
`default_nettype wire

### hdl/cis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cis_front: input word acceptance and candidate classification
// Three stage pipeline: deltas, fold and eta square, phi square; cone test
// at the queue push.
// ----------------------------------------------------------------------------
module cis_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cis_pkg::cfg_t        cfg,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_operation,
  input  wire logic [15:0]          in_pt,
  input  wire logic signed [13:0]   in_eta,
  input  wire logic signed [12:0]   in_phi,
  input  wire logic signed [1:0]    in_charge,
  input  wire logic signed [15:0]   in_dxy,
  input  wire logic signed [15:0]   in_dz,
  input  wire logic                 in_last,
  output logic                      q_push,
  output cis_pkg::entry_t           q_entry,
  input  wire logic                 q_full
);
  import cis_pkg::*;

  logic adv;
  logic in_acc;

  // probe direction
  logic signed [13:0] probe_eta_r;
  logic signed [12:0] probe_phi_r;

  // stage 1
  logic               v1_r, op1_r, last1_r, ptok1_r, chg1_r;
  logic [15:0]        pt1_r;
  logic signed [14:0] deta1_r;
  logic [12:0]        dphi1_r;
  // stage 2
  logic               v2_r, op2_r, last2_r, ptok2_r, chg2_r;
  logic [15:0]        pt2_r;
  logic [27:0]        deta_sq2_r;
  logic [11:0]        dphi2_r;
  // stage 3
  logic               v3_r, op3_r, last3_r, ptok3_r, chg3_r;
  logic [15:0]        pt3_r;
  logic [27:0]        deta_sq3_r;
  logic [23:0]        dphi_sq3_r;

  logic signed [14:0] deta_c;
  logic signed [13:0] dphi_diff, dphi_neg;
  logic [12:0]        dphi_abs;
  logic [16:0]        dxy_neg, dz_neg;
  logic [15:0]        dxy_mag, dz_mag;
  logic               chg_c;
  logic signed [13:0] fold_diff, fold_neg;
  logic [11:0]        dphi_f;
  logic signed [29:0] deta_prod;
  logic [28:0]        dr2;
  logic               in_cone;

  assign adv      = !(v3_r && q_full);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;
  assign q_push   = v3_r && adv;

  always_comb begin
    deta_c    = $signed({probe_eta_r[13], probe_eta_r}) - $signed({in_eta[13], in_eta});
    dphi_diff = $signed({probe_phi_r[12], probe_phi_r}) - $signed({in_phi[12], in_phi});
    dphi_neg  = -dphi_diff;
    dphi_abs  = dphi_diff[13] ? dphi_neg[12:0] : dphi_diff[12:0];
    dxy_neg   = -{in_dxy[15], in_dxy};
    dz_neg    = -{in_dz[15], in_dz};
    dxy_mag   = in_dxy[15] ? dxy_neg[15:0] : in_dxy;
    dz_mag    = in_dz[15] ? dz_neg[15:0] : in_dz;
    chg_c     = (in_charge != 2'sd0) && (dxy_mag < {1'b0, cfg.max_trans})
                && (dz_mag < {1'b0, cfg.max_long});
  end

  // fold delta-phi above pi back into 0..pi
  always_comb begin
    fold_diff = ANG_TWO_PI - $signed({1'b0, dphi1_r});
    fold_neg  = -fold_diff;
    dphi_f    = (dphi1_r > {1'b0, ANG_PI}) ?
                (fold_diff[13] ? fold_neg[11:0] : fold_diff[11:0]) : dphi1_r[11:0];
    deta_prod = deta1_r * deta1_r;
  end

  always_comb begin
    dr2     = {1'b0, deta_sq3_r} + {5'd0, dphi_sq3_r};
    in_cone = (op3_r == OP_CAND) && ptok3_r && (dr2 >= {19'd0, cfg.self_veto_dr2})
              && (dr2 <= {2'd0, cfg.cone_dr2});
    q_entry.start   = (op3_r == OP_START);
    q_entry.last    = last3_r;
    q_entry.add_all = in_cone;
    q_entry.add_chg = in_cone && chg3_r;
    q_entry.pt      = pt3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_eta_r <= '0;
      probe_phi_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else if (adv) begin
      if (in_acc && in_operation == OP_START) begin
        probe_eta_r <= in_eta;
        probe_phi_r <= in_phi;
      end
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r      <= in_operation;
      last1_r    <= in_last;
      pt1_r      <= in_pt;
      ptok1_r    <= (in_pt >= cfg.min_pt);
      chg1_r     <= chg_c;
      deta1_r    <= deta_c;
      dphi1_r    <= dphi_abs;

      op2_r      <= op1_r;
      last2_r    <= last1_r;
      pt2_r      <= pt1_r;
      ptok2_r    <= ptok1_r;
      chg2_r     <= chg1_r;
      deta_sq2_r <= deta_prod[27:0];
      dphi2_r    <= dphi_f;

      op3_r      <= op2_r;
      last3_r    <= last2_r;
      pt3_r      <= pt2_r;
      ptok3_r    <= ptok2_r;
      chg3_r     <= chg2_r;
      deta_sq3_r <= deta_sq2_r;
      dphi_sq3_r <= dphi2_r * dphi2_r;
    end
  end

endmodule : cis_front
`default_nettype wire

### hdl/cis_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cis_queue: small FIFO of classified words between front and back
// Register array with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module cis_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire cis_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output cis_pkg::entry_t      pop_entry,
  output logic                 empty
);
  import cis_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule : cis_queue
`default_nettype wire

### hdl/cis_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cis_back: sum accumulation and end-of-event isolation
// Pops one word a cycle while idle and the queue is not empty; on last runs two 32-step restoring dividers.
// ----------------------------------------------------------------------------
module cis_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cis_pkg::entry_t q_entry,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [23:0]          out_sum_all,
  output logic [23:0]          out_sum_charged,
  output logic [16:0]          out_iso_all,
  output logic [16:0]          out_iso_charged
);
  import cis_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int SCW = $clog2(DIV_STEPS);

  logic [1:0]     st_r, st_nxt;
  logic [15:0]    probe_pt_r;
  logic [23:0]    acc_all_r, acc_chg_r;
  logic [SCW-1:0] cnt_r;
  logic [24:0]    den_a_r, den_c_r, rem_a_r, rem_c_r;
  logic [31:0]    quo_a_r, quo_c_r;
  logic           out_valid_r;
  logic [23:0]    out_sum_all_r, out_sum_chg_r;
  logic [16:0]    out_iso_all_r, out_iso_chg_r;

  logic [24:0]    sum_a, sum_c;
  logic [23:0]    sat_a, sat_c;
  logic [56:0]    step_a, step_c;
  logic           out_free, out_load;

  function automatic logic [56:0] div_step(input logic [24:0] rem,
                                           input logic [31:0] q,
                                           input logic [24:0] den);
    logic [25:0] t;
    logic [25:0] d;
    t = {rem, q[31]};
    d = t - {1'b0, den};
    if (!d[25]) begin
      div_step = {d[24:0], q[30:0], 1'b1};
    end else begin
      div_step = {t[24:0], q[30:0], 1'b0};
    end
  endfunction

  assign q_pop    = (st_r == ST_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (st_r == ST_DONE) && out_free;

  always_comb begin
    sum_a  = {1'b0, acc_all_r} + {9'd0, q_entry.pt};
    sum_c  = {1'b0, acc_chg_r} + {9'd0, q_entry.pt};
    sat_a  = sum_a[24] ? SUM_MAX : sum_a[23:0];
    sat_c  = sum_c[24] ? SUM_MAX : sum_c[23:0];
    step_a = div_step(rem_a_r, quo_a_r, den_a_r);
    step_c = div_step(rem_c_r, quo_c_r, den_c_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_pop && q_entry.last) st_nxt = ST_SETUP;
      end
      ST_SETUP: st_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      probe_pt_r  <= '0;
      acc_all_r   <= '0;
      acc_chg_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (q_pop) begin
        if (q_entry.start) begin
          probe_pt_r <= q_entry.pt;
          acc_all_r  <= '0;
          acc_chg_r  <= '0;
        end else begin
          if (q_entry.add_all) acc_all_r <= sat_a;
          if (q_entry.add_chg) acc_chg_r <= sat_c;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_SETUP: begin
        den_a_r <= {1'b0, acc_all_r} + {9'd0, probe_pt_r};
        den_c_r <= {1'b0, acc_chg_r} + {9'd0, probe_pt_r};
        quo_a_r <= {probe_pt_r, 16'd0};
        quo_c_r <= {probe_pt_r, 16'd0};
        rem_a_r <= '0;
        rem_c_r <= '0;
        cnt_r   <= SCW'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        {rem_a_r, quo_a_r} <= step_a;
        {rem_c_r, quo_c_r} <= step_c;
        cnt_r              <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_sum_all_r <= acc_all_r;
      out_sum_chg_r <= acc_chg_r;
      // zero probe pt covers the zero-denominator case
      out_iso_all_r <= (probe_pt_r == '0) ? '0 : quo_a_r[16:0];
      out_iso_chg_r <= (probe_pt_r == '0) ? '0 : quo_c_r[16:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sum_all     = out_sum_all_r;
  assign out_sum_charged = out_sum_chg_r;
  assign out_iso_all     = out_iso_all_r;
  assign out_iso_charged = out_iso_chg_r;

  a_chg_le_all: assert property (@(posedge clk) disable iff (!rst_n)
    acc_chg_r <= acc_all_r)
    else $error("charged sum above all-particle sum");

  a_iso_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_iso_all_r <= 17'd65536) && (out_iso_chg_r <= 17'd65536))
    else $error("isolation above one");

endmodule : cis_back
`default_nettype wire
